[hw/rtl/tick_report_scheduler_assert.svh]
// assertion macros for the tick report scheduler
// used by tick_report_scheduler.sv, no other dependencies
`ifndef TICK_REPORT_SCHEDULER_ASSERT_SVH
`define TICK_REPORT_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define TRS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tick report scheduler assertion failed");

// next-cycle implication
`define TRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tick report scheduler assertion failed");

`endif

[hw/rtl/trs_pkg.sv]
// types and constants of the tick report scheduler
// no dependencies
package trs_pkg;

   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_FILL  = 3'd1,
      CMD_ACK   = 3'd2,
      CMD_LOAD  = 3'd3,
      CMD_CLEAR = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_REFRESH_HOURS = 2'd0,
      CSR_FILL_QUIET    = 2'd1,
      CSR_PING_MINUTES  = 2'd2,
      CSR_BACKLOG       = 2'd3
   } csr_idx_type;

   localparam int REQ_REFRESH = 0;
   localparam int REQ_FILL    = 1;
   localparam int REQ_PING    = 2;

   localparam logic [5:0] SEC_MAX      = 6'd59;
   localparam logic [5:0] MIN_MAX      = 6'd59;
   localparam logic [6:0] HOUR_MAX     = 7'd100;
   localparam logic [7:0] RETRY_LIMIT  = 8'd250;
   localparam logic [7:0] RETRY_CAP    = 8'd251;
   localparam logic [7:0] RETRY_HOLD   = 8'd100;
   localparam logic [7:0] RETRY_WIN_LO = 8'd20;
   localparam logic [7:0] RETRY_WIN_HI = 8'd21;

   localparam logic [6:0] RST_REFRESH_HOURS = 7'd4;
   localparam logic [7:0] RST_FILL_QUIET    = 8'd20;
   localparam logic [5:0] RST_PING_MINUTES  = 6'd4;
   localparam logic [6:0] RST_HOUR          = 7'd1;
   localparam logic [5:0] RST_PING          = 6'd5;
   localparam logic [7:0] RST_QUIET         = 8'd50;
   localparam logic [7:0] RST_RETRY         = 8'd100;
   localparam logic [2:0] RST_PENDING       = 3'b101;

   // first member sits in the top bits, so the list runs from the top field down
   typedef struct packed {
      logic [31:0] fill_stamp;
      logic [31:0] fill_total;
      logic [31:0] timestamp_now;
      logic        sleep_ok;
      logic [2:0]  requests;
   } res_type;

endpackage

[hw/rtl/tick_report_scheduler.sv]
// Tick report scheduler: accepts one command word per clock cycle while req_tready is high
// and returns one result word for each through the result register or skid stage. Every
// command (tick, fill pulse, acknowledge, load timestamp, clear fill count) updates the
// whole state in the one state-update stage, so the sustained rate is one word per cycle
// while the result side keeps up. A one-word skid stage lets the next command in while a
// result waits; input stalls only when both hold a word. Config writes are registered.
// Depends on trs_pkg and tick_report_scheduler_assert.svh
`include "tick_report_scheduler_assert.svh"

module tick_report_scheduler (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // clear_mask, load_value, zero fill
   input  logic [2:0]   req_tuser,   // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // requests, sleep_ok, timestamp_now, fill_total,
                                     // fill_stamp, zero fill
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   logic [6:0] refresh_hours_ff;
   logic [7:0] fill_quiet_ff;
   logic [5:0] ping_minutes_ff;
   logic       backlog_ff;

   logic [31:0] time_ff,    time_in;
   logic [31:0] total_ff,   total_in;
   logic [31:0] stamp_ff,   stamp_in;
   logic [5:0]  sec_ff,     sec_in;
   logic [5:0]  min_ff,     min_in;
   logic [6:0]  hour_ff,    hour_in;
   logic [5:0]  ping_ff,    ping_in;
   logic [7:0]  quiet_ff,   quiet_in;
   logic [7:0]  retry_ff,   retry_in;
   logic        armed_ff,   armed_in;
   logic [2:0]  pend_ff,    pend_in;

   trs_pkg::res_type res_ff,  res_in;
   trs_pkg::res_type skid_ff, skid_in;
   logic             rsp_vld_ff,  rsp_vld_in;
   logic             skid_vld_ff, skid_vld_in;
   logic             sleep_in;

   trs_pkg::cmd_type cmd;
   logic [2:0]       clear_mask;
   logic [31:0]      load_value;
   logic             req_fire;
   logic             rsp_pop;

   assign cmd        = trs_pkg::cmd_type'(req_tuser);
   assign clear_mask = req_tdata[2:0];
   assign load_value = req_tdata[34:3];
   assign req_tready = !skid_vld_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_pop    = rsp_vld_ff && rsp_tready;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0, res_ff};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_hours_ff <= trs_pkg::RST_REFRESH_HOURS;
         fill_quiet_ff    <= trs_pkg::RST_FILL_QUIET;
         ping_minutes_ff  <= trs_pkg::RST_PING_MINUTES;
         backlog_ff       <= 1'b0;
      end else if (csr_we) begin
         case (trs_pkg::csr_idx_type'(csr_index))
            trs_pkg::CSR_REFRESH_HOURS: refresh_hours_ff <= csr_wdata[6:0];
            trs_pkg::CSR_FILL_QUIET:    fill_quiet_ff    <= csr_wdata;
            trs_pkg::CSR_PING_MINUTES:  ping_minutes_ff  <= csr_wdata[5:0];
            trs_pkg::CSR_BACKLOG:       backlog_ff       <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // state update
   always_comb begin
      time_in  = time_ff;
      total_in = total_ff;
      stamp_in = stamp_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      ping_in  = ping_ff;
      quiet_in = quiet_ff;
      retry_in = retry_ff;
      armed_in = armed_ff;
      pend_in  = pend_ff;
      sleep_in = 1'b0;
      if (req_fire) begin
         case (cmd)
            trs_pkg::CMD_TICK: begin
               time_in  = time_ff + 32'd1;
               quiet_in = armed_ff ? quiet_ff + 8'd1 : 8'd0;
               retry_in = retry_ff + 8'd1;
               if (retry_in > trs_pkg::RETRY_LIMIT) begin
                  retry_in = trs_pkg::RETRY_CAP;
               end
               sec_in = sec_ff + 6'd1;
               if (sec_in > trs_pkg::SEC_MAX) begin
                  sec_in  = 6'd0;
                  min_in  = min_ff + 6'd1;
                  ping_in = ping_ff + 6'd1;
               end
               if (min_in > trs_pkg::MIN_MAX) begin
                  min_in  = 6'd0;
                  hour_in = hour_ff + 7'd1;
                  if (hour_in > trs_pkg::HOUR_MAX) begin
                     hour_in = 7'd0;
                  end
               end
               if (hour_in > refresh_hours_ff) begin
                  pend_in[trs_pkg::REQ_REFRESH] = 1'b1;
                  hour_in = 7'd0;
               end
               if ((armed_ff && quiet_in > fill_quiet_ff) ||
                   (backlog_ff && (retry_in == trs_pkg::RETRY_WIN_LO ||
                                   retry_in == trs_pkg::RETRY_WIN_HI))) begin
                  pend_in[trs_pkg::REQ_FILL] = 1'b1;
                  quiet_in = 8'd0;
                  retry_in = trs_pkg::RETRY_HOLD;
                  armed_in = 1'b0;
               end
               if (ping_in > ping_minutes_ff) begin
                  pend_in[trs_pkg::REQ_PING] = 1'b1;
                  ping_in = 6'd0;
               end
               sleep_in = (pend_in == 3'b000);
            end
            trs_pkg::CMD_FILL: begin
               total_in = total_ff + 32'd1;
               armed_in = 1'b1;
               stamp_in = time_ff;
            end
            trs_pkg::CMD_ACK: begin
               pend_in = pend_ff & ~clear_mask;
            end
            trs_pkg::CMD_LOAD: begin
               time_in = load_value;
               hour_in = 7'd0;
            end
            trs_pkg::CMD_CLEAR: begin
               total_in = 32'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff  <= 32'd0;
         total_ff <= 32'd0;
         stamp_ff <= 32'd0;
         sec_ff   <= 6'd0;
         min_ff   <= 6'd0;
         hour_ff  <= trs_pkg::RST_HOUR;
         ping_ff  <= trs_pkg::RST_PING;
         quiet_ff <= trs_pkg::RST_QUIET;
         retry_ff <= trs_pkg::RST_RETRY;
         armed_ff <= 1'b0;
         pend_ff  <= trs_pkg::RST_PENDING;
      end else begin
         time_ff  <= time_in;
         total_ff <= total_in;
         stamp_ff <= stamp_in;
         sec_ff   <= sec_in;
         min_ff   <= min_in;
         hour_ff  <= hour_in;
         ping_ff  <= ping_in;
         quiet_ff <= quiet_in;
         retry_ff <= retry_in;
         armed_ff <= armed_in;
         pend_ff  <= pend_in;
      end
   end

   // result register and skid stage
   always_comb begin
      res_in      = res_ff;
      skid_in     = skid_ff;
      rsp_vld_in  = rsp_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (rsp_pop || !rsp_vld_ff) begin
         if (skid_vld_ff) begin
            res_in      = skid_ff;
            rsp_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else if (req_fire) begin
            res_in     = '{fill_stamp: stamp_in, fill_total: total_in,
                           timestamp_now: time_in, sleep_ok: sleep_in,
                           requests: pend_in};
            rsp_vld_in = 1'b1;
         end else begin
            rsp_vld_in = 1'b0;
         end
      end else if (req_fire) begin
         skid_in     = '{fill_stamp: stamp_in, fill_total: total_in,
                         timestamp_now: time_in, sleep_ok: sleep_in,
                         requests: pend_in};
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      skid_ff <= skid_in;
   end

   `TRS_ASSERT_IMP(a_clock_range, clock, reset, 1'b1, sec_ff <= trs_pkg::SEC_MAX && min_ff <= trs_pkg::MIN_MAX && hour_ff <= trs_pkg::HOUR_MAX)
   `TRS_ASSERT_IMP(a_skid_behind_main, clock, reset, skid_vld_ff, rsp_vld_ff)
   `TRS_ASSERT_IMP(a_sleep_no_request, clock, reset, rsp_vld_ff && res_ff.sleep_ok, res_ff.requests == 3'b000)
   `TRS_ASSERT_NEXT(a_fill_arms, clock, reset, req_fire && cmd == trs_pkg::CMD_FILL, armed_ff)
   `TRS_ASSERT_NEXT(a_sleep_only_tick, clock, reset, req_fire && cmd != trs_pkg::CMD_TICK && (rsp_pop || !rsp_vld_ff) && !skid_vld_ff, !res_ff.sleep_ok)

endmodule

[verif/trs_checker.sv]
// checker for the tick report scheduler: watches the command, result and register ports,
// predicts each result word in its own copy of the scheduler state and compares in order
// depends on trs_pkg
module trs_checker
   import trs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [39:0]  req_tdata,    // clear_mask, load_value, zero fill
   input  logic [2:0]   req_tuser,    // cmd
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,    // requests, sleep_ok, timestamp_now, fill_total,
                                      // fill_stamp, zero fill
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata,
   output int           fail_count,
   output int           outstanding,
   output int           checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [6:0]  lim_refresh;
   logic [7:0]  lim_quiet;
   logic [5:0]  lim_ping;
   logic        backlog_on;

   logic [31:0] stamp_count;
   logic [31:0] fills_counted;
   logic [31:0] fill_time;
   logic [5:0]  secs;
   logic [5:0]  mins;
   logic [6:0]  hours;
   logic [5:0]  ping_mins;
   logic [7:0]  quiet_secs;
   logic [7:0]  retry_secs;
   logic        fill_armed;
   logic [2:0]  req_bits;

   res_type     due_reports[$];
   int          mismatches;
   int          compared;

   assign fail_count    = mismatches;
   assign checked_count = compared;

   task automatic clear_scheduler();
      lim_refresh   = RST_REFRESH_HOURS;
      lim_quiet     = RST_FILL_QUIET;
      lim_ping      = RST_PING_MINUTES;
      backlog_on    = 1'b0;
      stamp_count   = '0;
      fills_counted = '0;
      fill_time     = '0;
      secs          = '0;
      mins          = '0;
      hours         = RST_HOUR;
      ping_mins     = RST_PING;
      quiet_secs    = RST_QUIET;
      retry_secs    = RST_RETRY;
      fill_armed    = 1'b0;
      req_bits      = RST_PENDING;
   endtask

   function automatic res_type advance_scheduler(input logic [2:0] cmd,
                                                 input logic [2:0] mask,
                                                 input logic [31:0] load);
      res_type r;
      logic    doze;
      doze = 1'b0;
      case (cmd)
         CMD_TICK: begin
            stamp_count = stamp_count + 32'd1;
            quiet_secs  = fill_armed ? quiet_secs + 8'd1 : 8'd0;
            retry_secs  = (retry_secs >= RETRY_LIMIT) ? RETRY_CAP : retry_secs + 8'd1;
            if (secs >= SEC_MAX) begin
               secs      = '0;
               mins      = mins + 6'd1;
               ping_mins = ping_mins + 6'd1;
            end else begin
               secs = secs + 6'd1;
            end
            if (mins > MIN_MAX) begin
               mins  = '0;
               hours = (hours >= HOUR_MAX) ? 7'd0 : hours + 7'd1;
            end
            if (hours > lim_refresh) begin
               req_bits[REQ_REFRESH] = 1'b1;
               hours = '0;
            end
            if ((fill_armed && quiet_secs > lim_quiet) ||
                (backlog_on && retry_secs >= RETRY_WIN_LO && retry_secs <= RETRY_WIN_HI)) begin
               req_bits[REQ_FILL] = 1'b1;
               quiet_secs = '0;
               retry_secs = RETRY_HOLD;
               fill_armed = 1'b0;
            end
            if (ping_mins > lim_ping) begin
               req_bits[REQ_PING] = 1'b1;
               ping_mins = '0;
            end
            doze = (req_bits == 3'b000);
         end
         CMD_FILL: begin
            fills_counted = fills_counted + 32'd1;
            fill_armed    = 1'b1;
            fill_time     = stamp_count;
         end
         CMD_ACK:   req_bits = req_bits & ~mask;
         CMD_LOAD: begin
            stamp_count = load;
            hours       = '0;
         end
         CMD_CLEAR: fills_counted = '0;
         default: ;
      endcase
      r.requests      = req_bits;
      r.sleep_ok      = doze;
      r.timestamp_now = stamp_count;
      r.fill_total    = fills_counted;
      r.fill_stamp    = fill_time;
      return r;
   endfunction

   always @(posedge clock) begin
      res_type want;
      res_type got;
      int      bad;
      if (reset) begin
         clear_scheduler();
         due_reports.delete();
         mismatches = 0;
         compared   = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_REFRESH_HOURS: lim_refresh = csr_wdata[6:0];
               CSR_FILL_QUIET:    lim_quiet   = csr_wdata;
               CSR_PING_MINUTES:  lim_ping    = csr_wdata[5:0];
               CSR_BACKLOG:       backlog_on  = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(res_type)-1:0];
            compared++;
            if (due_reports.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result word %0d: req %b sleep %b ts %h total %h stamp %h",
                           compared, got.requests, got.sleep_ok, got.timestamp_now,
                           got.fill_total, got.fill_stamp);
               mismatches++;
            end else begin
               want = due_reports.pop_front();
               bad  = 0;
               if (got.requests      !== want.requests)      bad++;
               if (got.sleep_ok      !== want.sleep_ok)      bad++;
               if (got.timestamp_now !== want.timestamp_now) bad++;
               if (got.fill_total    !== want.fill_total)    bad++;
               if (got.fill_stamp    !== want.fill_stamp)    bad++;
               if (bad != 0) begin
                  if (mismatches < 10) begin
                     $display("mismatch at word %0d, %0d field(s) wrong", compared, bad);
                     $display("  expected req %b sleep %b ts %h total %h stamp %h",
                              want.requests, want.sleep_ok, want.timestamp_now,
                              want.fill_total, want.fill_stamp);
                     $display("  actual   req %b sleep %b ts %h total %h stamp %h",
                              got.requests, got.sleep_ok, got.timestamp_now,
                              got.fill_total, got.fill_stamp);
                  end
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            due_reports.push_back(advance_scheduler(req_tuser, req_tdata[2:0], req_tdata[34:3]));
      end
      outstanding <= due_reports.size();
   end

endmodule

[verif/tb_top.sv]
// top of the tick report scheduler testbench: clock, reset, command and register stimulus
// and the verdict; checking is done by trs_checker
// depends on trs_pkg, trs_checker and tick_report_scheduler
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import trs_pkg::*;

   localparam int LIMIT        = 3_000_000;
   localparam int PHASE_WORDS  = 160;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [39:0]  req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [7:0]   csr_wdata;

   int fail_count;
   int outstanding;
   int checked_count;
   int cycles;
   int settings_used;
   int sent_by_cmd[8];
   bit gaps_on  = 1'b1;
   bit stall_on = 1'b1;

   tick_report_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   trs_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[tick_report_scheduler] ERROR");
      $finish;
   end

   // result side back-pressure in short bursts
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic [2:0] cmd, input logic [2:0] mask,
                            input logic [31:0] load);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'b0, load, mask};
      do @(posedge clock); while (!req_tready);
      sent_by_cmd[cmd]++;
   endtask

   task automatic send_random_word();
      int          pick;
      logic [2:0]  cmd;
      logic [31:0] load;
      pick = $urandom_range(0, 99);
      load = $urandom;
      if (pick < 58)      cmd = CMD_TICK;
      else if (pick < 70) cmd = CMD_FILL;
      else if (pick < 84) cmd = CMD_ACK;
      else if (pick < 90) cmd = CMD_LOAD;
      else if (pick < 97) cmd = CMD_CLEAR;
      else                cmd = 3'($urandom_range(CMD_CLEAR + 1, 7));
      send_word(cmd, 3'($urandom_range(0, 7)), load);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic [6:0] refresh, input logic [7:0] quiet,
                             input logic [5:0] ping, input logic backlog);
      csr_we    <= 1'b1;
      csr_index <= CSR_REFRESH_HOURS;
      csr_wdata <= {1'b0, refresh};
      @(posedge clock);
      csr_index <= CSR_FILL_QUIET;
      csr_wdata <= quiet;
      @(posedge clock);
      csr_index <= CSR_PING_MINUTES;
      csr_wdata <= {2'b0, ping};
      @(posedge clock);
      csr_index <= CSR_BACKLOG;
      csr_wdata <= {7'b0, backlog};
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin
      logic [7:0] cfg[5][4];
      cfg = '{'{8'd1, 8'd1, 8'd1, 8'd1}, '{8'd100, 8'd250, 8'd59, 8'd0},
              '{8'd4, 8'd20, 8'd4, 8'd1}, '{8'd37, 8'd3, 8'd2, 8'd0},
              '{8'd0, 8'd0, 8'd0, 8'd0}};
      settings_used = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_TICK;
      csr_we     <= 1'b0;
      csr_index  <= CSR_REFRESH_HOURS;
      csr_wdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: a fill before any tick, acks, timestamp wrap, spare codes
      send_word(CMD_FILL, 3'b000, '0);
      send_word(CMD_TICK, 3'b000, '0);
      send_word(CMD_ACK, 3'b000, '0);
      send_word(CMD_ACK, 3'b111, '0);
      send_word(CMD_TICK, 3'b000, '0);
      send_word(CMD_LOAD, 3'b111, 32'hFFFF_FFFF);
      send_word(CMD_TICK, 3'b000, '0);
      send_word(CMD_FILL, 3'b000, '0);
      send_word(CMD_LOAD, 3'b000, 32'h0000_0000);
      send_word(CMD_LOAD, 3'b101, 32'hAAAA_AAAA);
      send_word(CMD_LOAD, 3'b010, 32'h5555_5555);
      send_word(CMD_FILL, 3'b000, '0);
      send_word(CMD_CLEAR, 3'b111, 32'hFFFF_FFFF);
      for (int c = CMD_CLEAR + 1; c < 8; c++)
         send_word(3'(c), 3'b111, 32'hFFFF_FFFF);
      for (int b = REQ_REFRESH; b <= REQ_PING; b++)
         send_word(CMD_ACK, 3'(1 << b), '0);
      repeat (3) send_word(CMD_TICK, 3'b000, '0);

      for (int p = 0; p < 5; p++) begin
         wait_drained();
         if (p == 4) begin
            cfg[p] = '{8'($urandom_range(1, 100)), 8'($urandom_range(1, 250)),
                       8'($urandom_range(1, 59)), 8'($urandom_range(0, 1))};
            gaps_on  = 1'b0;
            stall_on = 1'b0;
         end
         set_config(cfg[p][0][6:0], cfg[p][1], cfg[p][2][5:0], cfg[p][3][0]);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if ($urandom_range(0, 99) == 0)
               wait_drained();
            send_random_word();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("sent %0d ticks, %0d fills, %0d acks, %0d loads, %0d clears, %0d spare codes",
               sent_by_cmd[CMD_TICK], sent_by_cmd[CMD_FILL], sent_by_cmd[CMD_ACK],
               sent_by_cmd[CMD_LOAD], sent_by_cmd[CMD_CLEAR],
               sent_by_cmd[5] + sent_by_cmd[6] + sent_by_cmd[7]);
      $display("%0d result words compared across %0d register settings, %0d failures",
               checked_count, settings_used, fail_count + outstanding);
      if (fail_count == 0 && outstanding == 0)
         $display("[tick_report_scheduler] OK");
      else
         $display("[tick_report_scheduler] ERROR");
      $finish;
   end

endmodule
